FILE: rtl/core/lda_pkg.sv
`default_nettype none

package lda_pkg;

    localparam int FRAC_BITS        = 16;
    localparam int CORR_TABLE_DEPTH = 256;
    localparam int CORR_RANGE_SHIFT = 4;

    localparam int CORR_W     = FRAC_BITS;
    localparam int IDX_BITS   = $clog2(CORR_TABLE_DEPTH);
    localparam int CORR_SHIFT = FRAC_BITS + CORR_RANGE_SHIFT;
    localparam int WEIGHT_W   = CORR_SHIFT - IDX_BITS;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_MUL = 3'd1;
    localparam logic [2:0] CMD_DIV = 3'd2;
    localparam logic [2:0] CMD_GT  = 3'd3;
    localparam logic [2:0] CMD_LT  = 3'd4;
    localparam logic [2:0] CMD_EQ  = 3'd5;
    localparam logic [2:0] CMD_GE  = 3'd6;
    localparam logic [2:0] CMD_LE  = 3'd7;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] operand_a;
        logic signed [31:0] operand_b;
    } request_t;

    typedef struct packed {
        logic signed [31:0] result_value;
        logic               compare_flag;
        logic               saturated;
    } result_t;

    typedef logic [CORR_TABLE_DEPTH:0][CORR_W-1:0] corr_tab_t;

    localparam longint unsigned Q32_ONE      = 64'h0000_0001_0000_0000;
    localparam longint unsigned Q32_INV_E    = 64'd1580030169;
    localparam int              SERIES_TERMS = 24;

    // Restoring long division, used only while building the table
    function automatic longint unsigned udiv64(input longint unsigned num,
                                               input longint unsigned den);
        longint unsigned quo;
        longint unsigned rem;
        begin
            quo = 0;
            rem = 0;
            for (int i = 63; i >= 0; i--)
            begin
                rem = {rem[62:0], num[6'(i)]};
                quo = {quo[62:0], 1'b0};
                if (rem >= den)
                begin
                    rem    = rem - den;
                    quo[0] = 1'b1;
                end
            end
            return quo;
        end
    endfunction

    // e^-r, r in [0,1) as Q32; alternating Taylor series
    function automatic longint unsigned exp_neg_frac(input longint unsigned r);
        longint          sum;
        longint unsigned term;
        begin
            sum  = longint'(Q32_ONE);
            term = Q32_ONE;
            for (int n = 1; n <= SERIES_TERMS; n++)
            begin
                term = udiv64((term * r) >> 32, 64'(n));
                if ((n % 2) == 1)
                begin
                    sum = sum - longint'(term);
                end
                else
                begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0)
            begin
                sum = 0;
            end
            return longint'(sum);
        end
    endfunction

    // ln(1+y), y in [0,1] as Q32; 2*atanh(y/(2+y))
    function automatic longint unsigned log1p_q32(input longint unsigned y);
        longint unsigned z;
        longint unsigned z2;
        longint unsigned p;
        longint unsigned s;
        begin
            z  = udiv64(y << 31, 2 * Q32_ONE + y) << 1;
            z2 = (z * z) >> 32;
            p  = z;
            s  = 0;
            for (int n = 0; n < SERIES_TERMS; n++)
            begin
                s = s + udiv64(p, 64'(2 * n + 1));
                p = (p * z2) >> 32;
            end
            return 2 * s;
        end
    endfunction

    // Evaluated once at elaboration
    function automatic corr_tab_t build_corr_table();
        corr_tab_t       tab;
        longint unsigned num;
        longint unsigned whole;
        longint unsigned r;
        longint unsigned y;
        longint unsigned v;
        begin
            tab = '0;
            for (int i = 0; i <= CORR_TABLE_DEPTH; i++)
            begin
                num   = longint'(i) << CORR_RANGE_SHIFT;
                whole = num / CORR_TABLE_DEPTH;
                r     = ((num % CORR_TABLE_DEPTH) << 32) / CORR_TABLE_DEPTH;
                y     = exp_neg_frac(r);
                for (longint unsigned k = 0; k < whole; k++)
                begin
                    y = (y * Q32_INV_E) >> 32;
                end
                if (y > Q32_ONE)
                begin
                    y = Q32_ONE;
                end
                v = log1p_q32(y);
                v = (v + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
                tab[(IDX_BITS+1)'(i)] = v[CORR_W-1:0];
            end
            return tab;
        end
    endfunction

    localparam corr_tab_t CORR_TAB = build_corr_table();

endpackage

`default_nettype wire

FILE: rtl/core/log_domain_alu_unit.sv
`default_nettype none

// Log-domain ALU: add (log-sum-exp), mul, div and five compares on signed
// fixed-point natural-log values.
// Command channel: a transaction is taken on a rising edge with start high
// and busy low. busy never rises, so a new command may be issued each cycle.
// Result channel: done is high for one cycle with result valid alongside;
// the receiver cannot stall it and must take it in that cycle.
// Timing: the command is registered at the accepting edge and the result at
// the next edge, when done rises with it. Throughput: one transaction per cycle,
// set by the single compute stage between the request and result registers.
// Add reads two adjacent entries of a constant correction table and
// interpolates linearly; differences past the table range add nothing.
// Reset clears the valid flags only; no transaction is in flight after it.
module log_domain_alu_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire lda_pkg::request_t request,
    output logic                  done,
    output lda_pkg::result_t      result
);

    lda_pkg::request_t req_reg;
    logic              req_valid_reg;
    lda_pkg::result_t  res_reg;
    lda_pkg::result_t  res_next;
    logic              done_reg;

    logic signed [33:0]                 a_ext;
    logic signed [33:0]                 b_ext;
    logic signed [33:0]                 max_ext;
    logic signed [33:0]                 sum;
    logic [32:0]                        mag;
    logic                               a_gt;
    logic                               far;
    logic [lda_pkg::IDX_BITS-1:0]       idx;
    logic [lda_pkg::IDX_BITS:0]         idx_hi;
    logic [lda_pkg::CORR_W-1:0]         t0;
    logic [lda_pkg::CORR_W-1:0]         t1;
    logic [lda_pkg::CORR_W-1:0]         tdiff;
    logic [lda_pkg::WEIGHT_W-1:0]       weight;
    logic [lda_pkg::CORR_W+lda_pkg::WEIGHT_W-1:0] prod;
    logic [lda_pkg::CORR_W-1:0]         step;
    logic [lda_pkg::CORR_W-1:0]         corr;

    function automatic logic res_lt(input lda_pkg::request_t r);
        return r.operand_a < r.operand_b;
    endfunction

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            req_valid_reg <= start & ~busy;
            done_reg      <= req_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            req_reg <= request;
        end
        if (req_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    always_comb
    begin
        a_ext   = 34'(req_reg.operand_a);
        b_ext   = 34'(req_reg.operand_b);
        a_gt    = req_reg.operand_a > req_reg.operand_b;
        max_ext = a_gt ? a_ext : b_ext;
        mag     = a_gt ? 33'(a_ext - b_ext) : 33'(b_ext - a_ext);
        far     = (mag >> lda_pkg::CORR_SHIFT) != 33'd0;

        idx    = mag[lda_pkg::CORR_SHIFT-1 -: lda_pkg::IDX_BITS];
        idx_hi = {1'b0, idx} + 9'd1;
        weight = mag[lda_pkg::WEIGHT_W-1:0];
        t0     = lda_pkg::CORR_TAB[{1'b0, idx}];
        t1     = lda_pkg::CORR_TAB[idx_hi];
        tdiff  = (t0 >= t1) ? (t0 - t1) : (t1 - t0);
        prod   = (lda_pkg::CORR_W+lda_pkg::WEIGHT_W)'(tdiff)
               * (lda_pkg::CORR_W+lda_pkg::WEIGHT_W)'(weight);
        step   = prod[lda_pkg::CORR_W+lda_pkg::WEIGHT_W-1:lda_pkg::WEIGHT_W];
        if (far)
        begin
            corr = '0;
        end
        else if (t0 >= t1)
        begin
            corr = t0 - step;
        end
        else
        begin
            corr = t0 + step;
        end

        res_next = '0;
        case (req_reg.command)
            lda_pkg::CMD_ADD: sum = max_ext + 34'(corr);
            lda_pkg::CMD_MUL: sum = a_ext + b_ext;
            lda_pkg::CMD_DIV: sum = a_ext - b_ext;
            default:          sum = '0;
        endcase

        case (req_reg.command)
            lda_pkg::CMD_ADD, lda_pkg::CMD_MUL, lda_pkg::CMD_DIV:
            begin
                if (sum > 34'sd2147483647)
                begin
                    res_next.result_value = 32'sh7FFF_FFFF;
                    res_next.saturated    = 1'b1;
                end
                else if (sum < -34'sd2147483648)
                begin
                    res_next.result_value = 32'sh8000_0000;
                    res_next.saturated    = 1'b1;
                end
                else
                begin
                    res_next.result_value = sum[31:0];
                end
            end
            lda_pkg::CMD_GT: res_next.compare_flag = a_gt;
            lda_pkg::CMD_LT:
                res_next.compare_flag = req_reg.operand_a < req_reg.operand_b;
            lda_pkg::CMD_EQ:
                res_next.compare_flag = req_reg.operand_a == req_reg.operand_b;
            lda_pkg::CMD_GE: res_next.compare_flag = ~res_lt(req_reg);
            default:         res_next.compare_flag = ~a_gt;
        endcase
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

`default_nettype wire

FILE: bench/log_domain_alu_unit_tb.sv
`default_nettype none

module log_domain_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    typedef longint unsigned u64_t;

    localparam logic [31:0] S32_MAX     = 32'h7FFF_FFFF;
    localparam logic [31:0] S32_MIN     = 32'h8000_0000;
    localparam longint      S32_MAX_L   = 64'sd2147483647;
    localparam longint      S32_MIN_L   = -64'sd2147483648;
    localparam u64_t        ONE_Q32     = 64'h1_0000_0000;
    localparam u64_t        INV_E_Q32   = 64'd1580030169;
    localparam int          TERMS       = 24;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          MAX_REPORTS = 10;

    logic              clk;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    lda_pkg::request_t request = '0;
    logic              done;
    lda_pkg::result_t  result;

    log_domain_alu_unit DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .request(request),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ln(1 + e^-x) samples, Q(FRAC_BITS)
    u64_t             corr_lut [0:lda_pkg::CORR_TABLE_DEPTH];
    lda_pkg::result_t pending_results[$];
    lda_pkg::result_t want;
    int               send_idle_pct = 0;
    int               error_count   = 0;
    int               checked_count = 0;
    int               sat_count     = 0;
    int               cycle_count   = 0;
    int               cmd_hits [0:7];

    // e^-r for r in [0,1), Q32, alternating series
    function automatic u64_t q32_exp_neg(input u64_t r);
        longint acc;
        u64_t   term;
        u64_t   k;
        begin
            acc  = longint'(ONE_Q32);
            term = ONE_Q32;
            for (k = 1; k <= TERMS; k++)
            begin
                term = ((term * r) >> 32) / k;
                if (k[0])
                begin
                    acc = acc - longint'(term);
                end
                else
                begin
                    acc = acc + longint'(term);
                end
            end
            if (acc < 0)
            begin
                acc = 0;
            end
            return u64_t'(acc);
        end
    endfunction

    // ln(1+y) for y in [0,1], Q32, as 2*atanh(y/(2+y))
    function automatic u64_t q32_log1p(input u64_t y);
        u64_t z;
        u64_t z_sq;
        u64_t power;
        u64_t acc;
        u64_t k;
        begin
            z     = ((y << 31) / (2 * ONE_Q32 + y)) << 1;
            z_sq  = (z * z) >> 32;
            power = z;
            acc   = 0;
            for (k = 0; k < TERMS; k++)
            begin
                acc   = acc + power / (2 * k + 1);
                power = (power * z_sq) >> 32;
            end
            return 2 * acc;
        end
    endfunction

    task automatic fill_corr_lut();
        u64_t step;
        u64_t whole;
        u64_t frac;
        u64_t y;
        u64_t v;
        begin
            for (int i = 0; i <= lda_pkg::CORR_TABLE_DEPTH; i++)
            begin
                step  = u64_t'(i) << lda_pkg::CORR_RANGE_SHIFT;
                whole = step / lda_pkg::CORR_TABLE_DEPTH;
                frac  = ((step % lda_pkg::CORR_TABLE_DEPTH) << 32)
                        / lda_pkg::CORR_TABLE_DEPTH;
                y     = q32_exp_neg(frac);
                repeat (whole) y = (y * INV_E_Q32) >> 32;
                if (y > ONE_Q32)
                begin
                    y = ONE_Q32;
                end
                v = q32_log1p(y);
                v = (v + (u64_t'(1) << (31 - lda_pkg::FRAC_BITS)))
                    >> (32 - lda_pkg::FRAC_BITS);
                corr_lut[i] = v & ((u64_t'(1) << lda_pkg::FRAC_BITS) - 1);
            end
        end
    endtask

    function automatic longint lse_correction(input u64_t gap);
        u64_t scaled;
        u64_t idx;
        u64_t frac_w;
        u64_t lo;
        u64_t hi;
        begin
            if (gap >= (u64_t'(1) << lda_pkg::CORR_SHIFT))
            begin
                return 0;
            end
            scaled = gap * lda_pkg::CORR_TABLE_DEPTH;
            idx    = scaled >> lda_pkg::CORR_SHIFT;
            if (idx >= lda_pkg::CORR_TABLE_DEPTH)
            begin
                idx = lda_pkg::CORR_TABLE_DEPTH - 1;
            end
            frac_w = scaled & ((u64_t'(1) << lda_pkg::CORR_SHIFT) - 1);
            lo     = corr_lut[idx];
            hi     = corr_lut[idx + 1];
            if (lo >= hi)
            begin
                return longint'(lo - (((lo - hi) * frac_w) >> lda_pkg::CORR_SHIFT));
            end
            return longint'(lo + (((hi - lo) * frac_w) >> lda_pkg::CORR_SHIFT));
        end
    endfunction

    // {saturated, value}
    function automatic logic [32:0] clamp_s32(input longint v);
        begin
            if (v > S32_MAX_L)
            begin
                return {1'b1, S32_MAX};
            end
            if (v < S32_MIN_L)
            begin
                return {1'b1, S32_MIN};
            end
            return {1'b0, v[31:0]};
        end
    endfunction

    function automatic lda_pkg::result_t predict_log_alu(input lda_pkg::request_t req);
        lda_pkg::result_t r;
        longint           a;
        longint           b;
        longint           larger;
        u64_t             gap;
        logic [32:0]      clamped;
        begin
            r       = '0;
            clamped = '0;
            a       = longint'($signed(req.operand_a));
            b       = longint'($signed(req.operand_b));
            case (req.command)
                lda_pkg::CMD_ADD:
                begin
                    larger  = (a > b) ? a : b;
                    gap     = u64_t'((a > b) ? a - b : b - a);
                    clamped = clamp_s32(larger + lse_correction(gap));
                end
                lda_pkg::CMD_MUL: clamped = clamp_s32(a + b);
                lda_pkg::CMD_DIV: clamped = clamp_s32(a - b);
                lda_pkg::CMD_GT:  r.compare_flag = (a > b);
                lda_pkg::CMD_LT:  r.compare_flag = (a < b);
                lda_pkg::CMD_EQ:  r.compare_flag = (a == b);
                lda_pkg::CMD_GE:  r.compare_flag = (a >= b);
                default:          r.compare_flag = (a <= b);
            endcase
            r.result_value = clamped[31:0];
            r.saturated    = clamped[32];
            return r;
        end
    endfunction

    task automatic flag_error(input string msg);
        begin
            error_count++;
            if (error_count <= MAX_REPORTS)
            begin
                $display("[%0t] ERROR: %s", $realtime, msg);
            end
        end
    endtask

    // Result check first, then capture of a newly accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    flag_error($sformatf("unexpected result value=%h flag=%b sat=%b",
                        result.result_value, result.compare_flag, result.saturated));
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked_count++;
                    if (want.saturated)
                    begin
                        sat_count++;
                    end
                    if (result !== want)
                    begin
                        flag_error($sformatf(
                            "value exp %h got %h, flag exp %b got %b, sat exp %b got %b",
                            want.result_value, result.result_value,
                            want.compare_flag, result.compare_flag,
                            want.saturated, result.saturated));
                    end
                end
            end
            if (start && !busy)
            begin
                pending_results.push_back(predict_log_alu(request));
                cmd_hits[request.command]++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                cycle_count, pending_results.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Issues one transaction; start stays high on return so the next one can
    // follow back to back.
    task automatic send_op(input logic [2:0] cmd, input logic [31:0] a,
                           input logic [31:0] b);
        lda_pkg::request_t req;
        begin
            req.command   = cmd;
            req.operand_a = a;
            req.operand_b = b;
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                start <= 1'b0;
                @(posedge clk);
            end
            start   <= 1'b1;
            request <= req;
            @(posedge clk);
            while (busy) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] pick_extreme();
        begin
            case ($urandom_range(0, 5))
                0:       return S32_MAX;
                1:       return S32_MIN;
                2:       return 32'd0;
                3:       return 32'hFFFF_FFFF;
                4:       return 32'd1;
                default: return S32_MAX - 32'd1;
            endcase
        end
    endfunction

    task automatic test_add_corners();
        begin
            send_op(lda_pkg::CMD_ADD, 32'd0, 32'd0);                 // equal: full ln 2
            send_op(lda_pkg::CMD_ADD, S32_MAX, S32_MAX);             // saturates high
            send_op(lda_pkg::CMD_ADD, S32_MAX, S32_MAX - 32'd1);
            send_op(lda_pkg::CMD_ADD, S32_MIN, S32_MIN);
            send_op(lda_pkg::CMD_ADD, 32'h000F_FFFF, 32'd0);         // last table step
            send_op(lda_pkg::CMD_ADD, 32'd0, 32'h0010_0000);         // correction drops out
            send_op(lda_pkg::CMD_ADD, S32_MAX, S32_MIN);             // widest difference
            send_op(lda_pkg::CMD_ADD, 32'h0001_8000, 32'h0001_0000); // lands on a table entry
        end
    endtask

    task automatic test_mul_div_saturation();
        begin
            send_op(lda_pkg::CMD_MUL, S32_MAX, 32'd1);
            send_op(lda_pkg::CMD_MUL, S32_MIN, 32'hFFFF_FFFF);
            send_op(lda_pkg::CMD_MUL, S32_MIN, S32_MIN);
            send_op(lda_pkg::CMD_MUL, S32_MAX, S32_MIN);
            send_op(lda_pkg::CMD_DIV, S32_MIN, 32'd1);
            send_op(lda_pkg::CMD_DIV, 32'd0, S32_MIN);
            send_op(lda_pkg::CMD_DIV, 32'hFFFF_FFFF, S32_MAX);
        end
    endtask

    task automatic test_compares();
        logic [2:0] cmd;
        begin
            for (int c = lda_pkg::CMD_GT; c <= lda_pkg::CMD_LE; c++)
            begin
                cmd = 3'(c);
                send_op(cmd, 32'd5, 32'd5);
                if (c[0])
                begin
                    send_op(cmd, S32_MIN, S32_MAX);
                end
                else
                begin
                    send_op(cmd, S32_MAX, S32_MIN);
                end
            end
        end
    endtask

    // Close operand pairs four times in ten so add walks the correction table.
    task automatic test_random_mix(input int count);
        logic [2:0]  cmd;
        logic [31:0] a;
        logic [31:0] b;
        longint      offset;
        begin
            for (int n = 0; n < count; n++)
            begin
                cmd = ($urandom_range(0, 9) < 4) ? lda_pkg::CMD_ADD
                                                 : 3'($urandom_range(0, 7));
                a   = $urandom;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3:
                    begin
                        offset = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                        b      = 32'(longint'($signed(a)) + offset);
                    end
                    4, 5, 6: b = $urandom;
                    7:
                    begin
                        a = pick_extreme();
                        b = pick_extreme();
                    end
                    8:       b = a;
                    default: b = pick_extreme();
                endcase
                send_op(cmd, a, b);
            end
        end
    endtask

    initial
    begin
        foreach (cmd_hits[i]) cmd_hits[i] = 0;
        fill_corr_lut();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 37;
        test_add_corners();
        test_mul_div_saturation();
        test_compares();
        test_random_mix(275);
        send_idle_pct = 85;
        test_random_mix(275);
        send_idle_pct = 0;
        test_random_mix(275);
        start <= 1'b0;

        for (int w = 0; w < 50 && pending_results.size() != 0; w++)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", pending_results.size()));
        end

        $display("%0d transactions checked: add %0d, mul %0d, div %0d, compare %0d",
            checked_count, cmd_hits[lda_pkg::CMD_ADD], cmd_hits[lda_pkg::CMD_MUL],
            cmd_hits[lda_pkg::CMD_DIV],
            cmd_hits[lda_pkg::CMD_GT] + cmd_hits[lda_pkg::CMD_LT]
            + cmd_hits[lda_pkg::CMD_EQ] + cmd_hits[lda_pkg::CMD_GE]
            + cmd_hits[lda_pkg::CMD_LE]);
        $display("%0d saturated results, %0d errors", sat_count, error_count);
        if (error_count == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
